FILE: sv/btfl_pkg.sv
// types and constants for the beam toggle fog light controller
// no dependencies
package btfl_pkg;

  localparam int CNT_W = 7;

  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic [1:0] REG_TOGGLE_WINDOW = 2'd0;
  localparam logic [1:0] REG_WARN_COUNT    = 2'd1;
  localparam logic [1:0] REG_COUNTER_CAP   = 2'd2;

  localparam cnt_t TOGGLE_WINDOW_RST = 7'd12;
  localparam cnt_t WARN_COUNT_RST    = 7'd8;
  localparam cnt_t COUNTER_CAP_RST   = 7'd100;
  localparam cnt_t TICK_COUNTER_RST  = 7'd100;

endpackage

FILE: sv/beam_toggle_fog_light_controller.sv
// Fog light toggle controller: one low-beam sample per input beat, one result beat each.
// The block takes one beat per clock cycle while not stalled. Each accepted sample updates the
// sample ring, the qualified beam state, the fog light state and the tick counter
// in one register stage, and its result appears in the output register on the
// next cycle. A held output register stalls the input only while it is full and
// stalled itself, so a steady stream runs at one beat per cycle.
// Depends on btfl_pkg.
module beam_toggle_fog_light_controller
  import btfl_pkg::*;
#(
  parameter int SAMPLES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_raw_beam_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_fog_on,
  output logic        out_buzzer_on,
  output logic        out_beam_qualified_on,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PTR_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

  cnt_t toggle_window_r, warn_count_r, counter_cap_r;

  logic [SAMPLES-1:0] ring_r, ring_nxt;
  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic               beam_r, beam_nxt;
  logic               fog_r, fog_nxt;
  cnt_t               cnt_r, cnt_nxt;
  logic               buzz_nxt;

  logic out_valid_r, out_fog_r, out_buzz_r, out_beam_r;
  logic accept;
  logic cfg_wr;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      toggle_window_r <= TOGGLE_WINDOW_RST;
      warn_count_r    <= WARN_COUNT_RST;
      counter_cap_r   <= COUNTER_CAP_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_TOGGLE_WINDOW: toggle_window_r <= pwdata[CNT_W-1:0];
        REG_WARN_COUNT:    warn_count_r    <= pwdata[CNT_W-1:0];
        REG_COUNTER_CAP:   counter_cap_r   <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TOGGLE_WINDOW: prdata = {{(32-CNT_W){1'b0}}, toggle_window_r};
      REG_WARN_COUNT:    prdata = {{(32-CNT_W){1'b0}}, warn_count_r};
      REG_COUNTER_CAP:   prdata = {{(32-CNT_W){1'b0}}, counter_cap_r};
      default:           prdata = 32'd0;
    endcase
  end

  // handshake
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // next state for one sample
  always_comb begin
    logic now_on;
    logic cnt_mid_lt;
    cnt_t cnt_mid;
    ring_nxt        = ring_r;
    ring_nxt[ptr_r] = in_raw_beam_level;
    ptr_nxt         = (ptr_r == PTR_W'(SAMPLES-1)) ? '0 : ptr_r + 1'b1;
    now_on          = (ring_nxt == '0);
    fog_nxt         = fog_r;
    cnt_mid         = cnt_r;
    if (now_on != beam_r) begin
      if (!now_on) begin
        if (!fog_r) cnt_mid = '0;
      end else if (cnt_r < toggle_window_r) begin
        fog_nxt = !fog_r;
      end else begin
        fog_nxt = 1'b0;
      end
    end
    beam_nxt   = now_on;
    buzz_nxt   = (cnt_mid == warn_count_r) && in_raw_beam_level && !fog_nxt;
    cnt_mid_lt = cnt_mid < counter_cap_r;
    cnt_nxt    = cnt_mid_lt ? cnt_mid + 1'b1 : cnt_mid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SAMPLES; i++) begin
        ring_r[i] <= 1'(i % 2);
      end
      ptr_r  <= '0;
      beam_r <= 1'b0;
      fog_r  <= 1'b0;
      cnt_r  <= TICK_COUNTER_RST;
    end else if (accept) begin
      ring_r <= ring_nxt;
      ptr_r  <= ptr_nxt;
      beam_r <= beam_nxt;
      fog_r  <= fog_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_fog_r  <= fog_nxt;
      out_buzz_r <= buzz_nxt;
      out_beam_r <= beam_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_fog_on            = out_fog_r;
  assign out_buzzer_on         = out_buzz_r;
  assign out_beam_qualified_on = out_beam_r;

  a_accept_fills_out : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted beat did not reach the output register");

  a_buzz_fog_off : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_buzz_r) |-> !out_fog_r)
    else $error("buzzer sounding with fog light on");

  a_buzz_beam_off : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_buzz_r) |-> !out_beam_r)
    else $error("buzzer sounding with beam qualified on");

  a_fog_follows_beam : assert property (@(posedge clk) disable iff (!rst_n)
    (fog_r != $past(fog_r)) |-> (beam_r != $past(beam_r)))
    else $error("fog light changed without a beam change");

endmodule
